### src/smrw_pkg.sv
// Shared widths, codes and types for the stereo mid/side resonant widener.
// No dependencies; used by smrw_mulsh and the top level.
package smrw_pkg;

  localparam int unsigned SampleW  = 24;
  localparam int unsigned CoefW    = 32;
  localparam int unsigned DelayW   = 40;
  localparam int unsigned NumFilt  = 9;
  localparam int unsigned NumCoef  = 3 * NumFilt;
  localparam int unsigned NumDelay = 2 * NumFilt;
  localparam int unsigned OpAW     = 49;
  localparam int unsigned OpBW     = 33;
  localparam int unsigned CfgW     = 19;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CoefIdxW = 5;
  localparam int unsigned FiltW    = 4;

  typedef enum logic [1:0] {
    SH16,
    SH28,
    SH30
  } shift_e;

  typedef struct packed {
    logic   start;
    shift_e sh;
  } mul_req_t;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_GAIN_MID     = 3'd0,
    CFG_GAIN_SIDE    = 3'd1,
    CFG_DEPTH_MID    = 3'd2,
    CFG_DEPTH_SIDE   = 3'd3,
    CFG_OUTPUT_LEVEL = 3'd4,
    CFG_NONLIN       = 3'd5,
    CFG_WET_MIX      = 3'd6
  } cfg_reg_e;

endpackage

### src/smrw_mulsh.sv
// Shared multi-cycle multiplier: round(a*b / 2^sh), half away from zero.
// One 32x33 multiplier used twice per product. Depends on smrw_pkg.
module smrw_mulsh (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  smrw_pkg::mul_req_t                   req_i,
  input  logic signed [smrw_pkg::OpAW-1:0]     a_i,
  input  logic signed [smrw_pkg::OpBW-1:0]     b_i,
  output logic                                 done_o,
  output logic signed [smrw_pkg::OpAW-1:0]     res_o
);
  import smrw_pkg::*;

  localparam int unsigned MagW  = OpAW - 1;
  localparam int unsigned LoW   = 32;
  localparam int unsigned ProdW = LoW + OpBW;
  localparam int unsigned AccW  = ProdW + 1;
  localparam int unsigned FullW = ProdW + LoW;

  logic [MagW-1:0]  ma_q;
  logic [OpBW-1:0]  mb_q;
  logic             neg_q;
  shift_e           sh_q;
  logic [1:0]       ph_q;
  logic             busy_q;
  logic             done_q;
  logic [ProdW-1:0] prod_q;
  logic [AccW-1:0]  acc_q;
  logic [MagW-1:0]  mag_q;

  logic [OpAW-1:0]  a_abs;
  logic [OpBW-1:0]  b_abs;
  logic [LoW-1:0]   opx;
  logic [ProdW-1:0] mprod;
  logic [AccW-1:0]  rnd;
  logic [FullW-1:0] full;
  logic [FullW-1:0] shifted;

  assign a_abs = a_i[OpAW-1] ? -a_i : a_i;
  assign b_abs = b_i[OpBW-1] ? -b_i : b_i;
  assign opx   = (ph_q == 2'd0) ? ma_q[LoW-1:0] : LoW'(ma_q[MagW-1:LoW]);
  assign mprod = ProdW'(opx) * ProdW'(mb_q);
  assign full  = {prod_q, {LoW{1'b0}}} + FullW'(acc_q);

  always_comb begin
    case (sh_q)
      SH16:    rnd = AccW'(1) << 15;
      SH28:    rnd = AccW'(1) << 27;
      SH30:    rnd = AccW'(1) << 29;
      default: rnd = '0;
    endcase
  end

  always_comb begin
    case (sh_q)
      SH16:    shifted = full >> 16;
      SH28:    shifted = full >> 28;
      SH30:    shifted = full >> 30;
      default: shifted = full;
    endcase
  end

  assign res_o  = neg_q ? -$signed({1'b0, mag_q}) : $signed({1'b0, mag_q});
  assign done_o = done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ma_q   <= '0;
      mb_q   <= '0;
      neg_q  <= 1'b0;
      sh_q   <= SH16;
      ph_q   <= 2'd0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
      prod_q <= '0;
      acc_q  <= '0;
      mag_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start && !busy_q) begin
        ma_q   <= a_abs[MagW-1:0];
        mb_q   <= b_abs;
        neg_q  <= a_i[OpAW-1] ^ b_i[OpBW-1];
        sh_q   <= req_i.sh;
        ph_q   <= 2'd0;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        case (ph_q)
          2'd0: begin
            prod_q <= mprod;
            ph_q   <= 2'd1;
          end
          2'd1: begin
            acc_q  <= AccW'(prod_q) + rnd;
            prod_q <= mprod;
            ph_q   <= 2'd2;
          end
          default: begin
            mag_q  <= shifted[MagW-1:0];
            busy_q <= 1'b0;
            done_q <= 1'b1;
          end
        endcase
      end
    end
  end

endmodule

### src/stereo_midside_resonant_widener_core.sv
// Top level of the stereo mid/side resonant widener: sequencer, coefficient
// and delay memories, configuration registers. Depends on smrw_pkg, smrw_mulsh.
//
//   channel | direction | handshake                | payload
//   in      | in        | in_valid_i / in_ready_o  | kind, left_in, right_in, coef_index/value
//   out     | out       | out_valid_o / out_ready_i| left_out, right_out
//   cfg     | in        | cfg_valid_i / cfg_ready_o| cfg_index_i, cfg_data_i
//
// A sample item's time from acceptance back to ready is set by the single shared
// multiplier (52 to 58 products per item); each biquad's memory fetches overlap its
// first product. A coefficient write is stored without leaving the idle state.
// Reset clears registers and memory valid bits at once; no clearing pass.
// A finished item waits in the output register while the next is accepted.
module stereo_midside_resonant_widener_core (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     in_valid_i,
  output logic                                     in_ready_o,
  input  logic                                     kind_i,
  input  logic signed [smrw_pkg::SampleW-1:0]      left_in_i,
  input  logic signed [smrw_pkg::SampleW-1:0]      right_in_i,
  input  logic        [smrw_pkg::CoefIdxW-1:0]     coef_index_i,
  input  logic signed [smrw_pkg::CoefW-1:0]        coef_value_i,
  output logic                                     out_valid_o,
  input  logic                                     out_ready_i,
  output logic signed [smrw_pkg::SampleW-1:0]      left_out_o,
  output logic signed [smrw_pkg::SampleW-1:0]      right_out_o,
  input  logic                                     cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  logic        [smrw_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic        [smrw_pkg::CfgW-1:0]         cfg_data_i
);
  import smrw_pkg::*;

  localparam int unsigned W     = OpAW;
  localparam int unsigned GW    = CoefW - 3;
  localparam int unsigned Shift = (DelayW - 10) - (SampleW - 1);
  localparam logic [16:0] Unity = 17'h10000;
  localparam logic signed [W-1:0] DMax = {{(W-DelayW+1){1'b0}}, {(DelayW-1){1'b1}}};
  localparam logic signed [W-1:0] DMin = ~DMax;
  localparam logic signed [W-1:0] SMax = {{(W-SampleW+1){1'b0}}, {(SampleW-1){1'b1}}};
  localparam logic signed [W-1:0] SMin = ~SMax;
  localparam logic signed [W-1:0] GLim = {{(W-CoefW+3){1'b0}}, 1'b1, {(CoefW-4){1'b0}}};
  localparam logic signed [W-1:0] OneD = {{(W-DelayW+9){1'b0}}, 1'b1, {(DelayW-10){1'b0}}};
  localparam logic signed [W-1:0] RndPos = W'(1) << (Shift - 1);
  localparam logic signed [W-1:0] RndNeg = RndPos - W'(1);

  typedef enum logic [3:0] {
    S_IDLE, S_F0, S_F1, S_F2, S_F3, S_ISSUE, S_WAIT, S_FIN, S_OUT
  } state_e;

  typedef enum logic [3:0] {
    OP_N, OP_G, OP_P, OP_TB1, OP_TB2, OP_SDS, OP_FM, OP_FS,
    OP_PL, OP_PR, OP_GM, OP_GS, OP_LVL, OP_WET, OP_DRY
  } op_e;

  function automatic logic signed [W-1:0] half_away(input logic signed [W-1:0] v);
    logic signed [W-1:0] tmp;
    tmp = v + $signed({{(W-1){1'b0}}, ~v[W-1]});
    return tmp >>> 1;
  endfunction

  function automatic logic signed [DelayW-1:0] sat_d(input logic signed [W-1:0] v);
    logic signed [W-1:0] c;
    c = (v > DMax) ? DMax : ((v < DMin) ? DMin : v);
    return c[DelayW-1:0];
  endfunction

  // configuration registers
  logic [16:0] gain_mid_q, output_level_q, nonlin_q, wet_mix_q;
  logic [18:0] gain_side_q;
  logic [17:0] depth_mid_q, depth_side_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_mid_q     <= 17'h10000;
      gain_side_q    <= 19'h10000;
      depth_mid_q    <= 18'h08000;
      depth_side_q   <= 18'h08000;
      output_level_q <= 17'h10000;
      nonlin_q       <= '0;
      wet_mix_q      <= 17'h10000;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_GAIN_MID:     gain_mid_q     <= cfg_data_i[16:0];
        CFG_GAIN_SIDE:    gain_side_q    <= cfg_data_i;
        CFG_DEPTH_MID:    depth_mid_q    <= cfg_data_i[17:0];
        CFG_DEPTH_SIDE:   depth_side_q   <= cfg_data_i[17:0];
        CFG_OUTPUT_LEVEL: output_level_q <= cfg_data_i[16:0];
        CFG_NONLIN:       nonlin_q       <= cfg_data_i[16:0];
        CFG_WET_MIX:      wet_mix_q      <= cfg_data_i[16:0];
        default: ;
      endcase
    end
  end

  state_e state_q;
  op_e    op_q;
  logic [FiltW-1:0] f_q;
  logic   chan_q;
  logic   out_valid_q;
  logic signed [SampleW-1:0] out_l_q, out_r_q, lres_q, rres_q;
  logic signed [W-1:0] l_q, r_q, mid_q, side_q, iso_q;
  logic signed [W-1:0] n_q, p_q, fm_acc_q, fs_acc_q, pl_acc_q, pr_acc_q;
  logic signed [W-1:0] fm_q, msl_q, msr_q, pl_q, pr_q, gm_q, wr_q, fin_q, wtmp_q;
  logic [GW-1:0] g_q;
  logic signed [DelayW-1:0] t_q, d1_q, d2_q;
  logic signed [CoefW-1:0] a0_q, b1_q, b2_q;

  // memories
  logic signed [CoefW-1:0]  coef_mem [NumCoef];
  logic signed [DelayW-1:0] delay_mem [NumDelay];
  logic [NumCoef-1:0]  cvld_q;
  logic [NumDelay-1:0] dvld_q;
  logic signed [CoefW-1:0]  crd_q;
  logic signed [DelayW-1:0] drd_q;
  logic crv_q, drv_q;
  logic [CoefIdxW-1:0] cbase, caddr;
  logic [CoefIdxW-1:0] dbase, daddr, dwaddr;
  logic signed [CoefW-1:0]  coef_rd;
  logic signed [DelayW-1:0] delay_rd;
  logic cwe, dwe;
  logic signed [DelayW-1:0] dwdata;

  logic in_acc;
  assign in_acc     = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == S_IDLE);
  assign cwe        = in_acc && kind_i && (coef_index_i < CoefIdxW'(NumCoef));

  assign cbase = CoefIdxW'({f_q, 1'b0}) + CoefIdxW'(f_q);
  assign dbase = CoefIdxW'({f_q, 1'b0});

  always_comb begin
    case (state_q)
      S_F1:    caddr = cbase + CoefIdxW'(1);
      S_F2:    caddr = cbase + CoefIdxW'(2);
      default: caddr = cbase;
    endcase
  end
  assign daddr  = (state_q == S_F1) ? dbase + CoefIdxW'(1) : dbase;
  assign dwaddr = (op_q == OP_TB2) ? dbase + CoefIdxW'(1) : dbase;

  always_ff @(posedge clk_i) begin
    if (cwe) begin
      coef_mem[coef_index_i] <= coef_value_i;
    end
    crd_q <= coef_mem[caddr];
  end

  always_ff @(posedge clk_i) begin
    if (dwe) begin
      delay_mem[dwaddr] <= dwdata;
    end
    drd_q <= delay_mem[daddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cvld_q <= '0;
      dvld_q <= '0;
      crv_q  <= 1'b0;
      drv_q  <= 1'b0;
    end else begin
      if (cwe) cvld_q[coef_index_i] <= 1'b1;
      if (dwe) dvld_q[dwaddr] <= 1'b1;
      crv_q <= cvld_q[caddr];
      drv_q <= dvld_q[daddr];
    end
  end

  assign coef_rd  = crv_q ? crd_q : '0;
  assign delay_rd = drv_q ? drd_q : '0;

  // multiplier operands
  mul_req_t mreq;
  logic signed [W-1:0]    op_a, x_sel, res;
  logic signed [OpBW-1:0] op_b;
  logic mul_done;

  always_comb begin
    case (f_q)
      4'd0, 4'd1, 4'd2: x_sel = mid_q;
      4'd3, 4'd4:       x_sel = side_q;
      4'd5, 4'd7:       x_sel = iso_q;
      default:          x_sel = -iso_q;
    endcase
  end

  always_comb begin
    op_a       = x_sel;
    op_b       = '0;
    mreq.start = (state_q == S_ISSUE) || (state_q == S_F0);
    mreq.sh    = SH16;
    case (op_q)
      OP_N:   op_b = OpBW'(nonlin_q);
      OP_G: begin
        op_a = OneD + n_q;  op_b = OpBW'(a0_q);  mreq.sh = SH30;
      end
      OP_P: begin
        op_b = OpBW'(g_q);  mreq.sh = SH28;
      end
      OP_TB1: begin
        op_a = W'(t_q);  op_b = OpBW'(b1_q);  mreq.sh = SH28;
      end
      OP_TB2: begin
        op_a = W'(t_q);  op_b = OpBW'(b2_q);  mreq.sh = SH28;
      end
      OP_SDS: begin op_a = side_q;   op_b = OpBW'(depth_side_q); end
      OP_FM:  begin op_a = fm_acc_q; op_b = OpBW'(depth_mid_q);  end
      OP_FS:  begin op_a = fs_acc_q; op_b = OpBW'(depth_side_q); end
      OP_PL:  begin op_a = pl_acc_q; op_b = OpBW'(depth_side_q); end
      OP_PR:  begin op_a = pr_acc_q; op_b = OpBW'(depth_side_q); end
      OP_GM:  begin op_a = mid_q;    op_b = OpBW'(gain_mid_q);   end
      OP_GS:  begin op_a = side_q;   op_b = OpBW'(gain_side_q);  end
      OP_LVL: begin op_a = fin_q;    op_b = OpBW'(output_level_q); end
      OP_WET: begin op_a = fin_q;    op_b = OpBW'(wet_mix_q);    end
      OP_DRY: begin
        op_a = chan_q ? r_q : l_q;
        op_b = OpBW'(Unity) - OpBW'(wet_mix_q);
      end
      default: ;
    endcase
  end

  smrw_mulsh u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mreq),
    .a_i    (op_a),
    .b_i    (op_b),
    .done_o (mul_done),
    .res_o  (res)
  );

  // per-op datapath values
  logic signed [W-1:0] tw, wt, gabs, in_l, in_r, sd, fin_r, fin_sh;
  logic signed [DelayW-1:0] d1n, d2n;
  logic signed [SampleW-1:0] fin_val;
  logic lvl_on, wet_on;

  assign tw   = W'(t_q);
  assign gabs = res[W-1] ? -res : res;
  assign d1n  = sat_d(W'(d2_q) - res);
  assign d2n  = sat_d(-p_q - res);
  assign dwe  = (state_q == S_WAIT) && mul_done && ((op_q == OP_TB1) || (op_q == OP_TB2));
  assign dwdata = (op_q == OP_TB1) ? d1n : d2n;

  assign in_l = W'(left_in_i) <<< Shift;
  assign in_r = W'(right_in_i) <<< Shift;
  assign sd   = in_l - in_r;

  assign lvl_on = !output_level_q[16];
  assign wet_on = (wet_mix_q != Unity);

  assign fin_r  = fin_q + (fin_q[W-1] ? RndNeg : RndPos);
  assign fin_sh = fin_r >>> Shift;
  always_comb begin
    if (fin_sh > SMax)      fin_val = SMax[SampleW-1:0];
    else if (fin_sh < SMin) fin_val = SMin[SampleW-1:0];
    else                    fin_val = fin_sh[SampleW-1:0];
  end

  always_comb begin
    case (f_q)
      4'd0, 4'd5, 4'd6: wt = tw;
      4'd1, 4'd2:       wt = -(tw <<< 1);
      4'd3:             wt = tw <<< 1;
      4'd4:             wt = -((tw <<< 2) + tw);
      default:          wt = (tw <<< 1) + tw;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign left_out_o  = out_l_q;
  assign right_out_o = out_r_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      op_q        <= OP_N;
      f_q         <= '0;
      chan_q      <= 1'b0;
      out_valid_q <= 1'b0;
      out_l_q     <= '0;
      out_r_q     <= '0;
      lres_q      <= '0;
      rres_q      <= '0;
      l_q         <= '0;
      r_q         <= '0;
      mid_q       <= '0;
      side_q      <= '0;
      iso_q       <= '0;
      n_q         <= '0;
      p_q         <= '0;
      g_q         <= '0;
      t_q         <= '0;
      d1_q        <= '0;
      d2_q        <= '0;
      a0_q        <= '0;
      b1_q        <= '0;
      b2_q        <= '0;
      fm_acc_q    <= '0;
      fs_acc_q    <= '0;
      pl_acc_q    <= '0;
      pr_acc_q    <= '0;
      fm_q        <= '0;
      msl_q       <= '0;
      msr_q       <= '0;
      pl_q        <= '0;
      pr_q        <= '0;
      gm_q        <= '0;
      wr_q        <= '0;
      fin_q       <= '0;
      wtmp_q      <= '0;
    end else begin
      if (out_valid_q && out_ready_i && (state_q != S_OUT)) out_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (in_valid_i && !kind_i) begin
            l_q      <= in_l;
            r_q      <= in_r;
            mid_q    <= in_l + in_r;
            side_q   <= sd;
            iso_q    <= half_away(sd);
            f_q      <= '0;
            fm_acc_q <= '0;
            fs_acc_q <= '0;
            pl_acc_q <= '0;
            pr_acc_q <= '0;
            op_q     <= OP_N;
            state_q  <= S_F0;
          end
        end
        S_F0: state_q <= S_F1;
        S_F1: begin
          a0_q    <= coef_rd;
          d1_q    <= delay_rd;
          state_q <= S_F2;
        end
        S_F2: begin
          b1_q    <= coef_rd;
          d2_q    <= delay_rd;
          state_q <= S_F3;
        end
        S_F3: begin
          b2_q    <= coef_rd;
          state_q <= S_WAIT;
        end
        S_ISSUE: state_q <= S_WAIT;
        S_WAIT: begin
          if (mul_done) begin
            case (op_q)
              OP_N: begin
                n_q     <= res;
                op_q    <= OP_G;
                state_q <= S_ISSUE;
              end
              OP_G: begin
                g_q     <= (gabs > GLim) ? GLim[GW-1:0] : gabs[GW-1:0];
                op_q    <= OP_P;
                state_q <= S_ISSUE;
              end
              OP_P: begin
                p_q     <= res;
                t_q     <= sat_d(res + W'(d1_q));
                op_q    <= OP_TB1;
                state_q <= S_ISSUE;
              end
              OP_TB1: begin
                case (f_q)
                  4'd0, 4'd1, 4'd2: fm_acc_q <= fm_acc_q + wt;
                  4'd3, 4'd4:       fs_acc_q <= fs_acc_q + wt;
                  4'd5, 4'd7:       pl_acc_q <= pl_acc_q + wt;
                  default:          pr_acc_q <= pr_acc_q + wt;
                endcase
                op_q    <= OP_TB2;
                state_q <= S_ISSUE;
              end
              OP_TB2: begin
                if (f_q == FiltW'(NumFilt - 1)) begin
                  op_q    <= OP_SDS;
                  state_q <= S_ISSUE;
                end else begin
                  f_q     <= f_q + FiltW'(1);
                  op_q    <= OP_N;
                  state_q <= S_F0;
                end
              end
              OP_SDS: begin
                fs_acc_q <= fs_acc_q + res;
                op_q     <= OP_FM;
                state_q  <= S_ISSUE;
              end
              OP_FM: begin
                fm_q    <= res;
                op_q    <= OP_FS;
                state_q <= S_ISSUE;
              end
              OP_FS: begin
                msl_q   <= half_away(fm_q + res);
                msr_q   <= half_away(fm_q - res);
                op_q    <= OP_PL;
                state_q <= S_ISSUE;
              end
              OP_PL: begin
                pl_q    <= msl_q + res;
                op_q    <= OP_PR;
                state_q <= S_ISSUE;
              end
              OP_PR: begin
                pr_q    <= msr_q + res;
                op_q    <= OP_GM;
                state_q <= S_ISSUE;
              end
              OP_GM: begin
                gm_q    <= res;
                op_q    <= OP_GS;
                state_q <= S_ISSUE;
              end
              OP_GS: begin
                fin_q  <= half_away(gm_q + res) + pl_q;
                wr_q   <= half_away(gm_q - res) + pr_q;
                chan_q <= 1'b0;
                if (lvl_on) begin
                  op_q    <= OP_LVL;
                  state_q <= S_ISSUE;
                end else if (wet_on) begin
                  op_q    <= OP_WET;
                  state_q <= S_ISSUE;
                end else begin
                  state_q <= S_FIN;
                end
              end
              OP_LVL: begin
                fin_q <= res;
                if (wet_on) begin
                  op_q    <= OP_WET;
                  state_q <= S_ISSUE;
                end else begin
                  state_q <= S_FIN;
                end
              end
              OP_WET: begin
                wtmp_q  <= res;
                op_q    <= OP_DRY;
                state_q <= S_ISSUE;
              end
              default: begin
                fin_q   <= wtmp_q + res;
                state_q <= S_FIN;
              end
            endcase
          end
        end
        S_FIN: begin
          if (!chan_q) begin
            lres_q <= fin_val;
            chan_q <= 1'b1;
            fin_q  <= wr_q;
            if (lvl_on) begin
              op_q    <= OP_LVL;
              state_q <= S_ISSUE;
            end else if (wet_on) begin
              op_q    <= OP_WET;
              state_q <= S_ISSUE;
            end
          end else begin
            rres_q  <= fin_val;
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid_q || out_ready_i) begin
            out_l_q     <= lres_q;
            out_r_q     <= rres_q;
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

### bench/stereo_midside_resonant_widener_core_test.sv
// Self-checking bench for stereo_midside_resonant_widener_core: random and directed
// sample and coefficient-write items, with a bit-exact predictor of the filter network.
// Depends on smrw_pkg and the core RTL.
module stereo_midside_resonant_widener_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import smrw_pkg::*;

  localparam longint Clamp62 = 64'sd1 <<< 62;
  localparam longint OneD    = 64'sd1 <<< 30;
  localparam longint OneC    = 64'sd1 <<< 28;
  localparam int     Unity   = 65536;
  localparam bit     KindPair = 1'b0;
  localparam bit     KindCoef = 1'b1;

  typedef struct {
    bit              kind;
    logic [SampleW-1:0] l;
    logic [SampleW-1:0] r;
    logic [CoefIdxW-1:0] idx;
    logic [CoefW-1:0]    val;
  } item_t;

  typedef struct {
    logic [SampleW-1:0] l;
    logic [SampleW-1:0] r;
  } pair_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0, kind = 1'b0;
  logic [SampleW-1:0] left_in = '0, right_in = '0;
  logic [CoefIdxW-1:0] coef_index = '0;
  logic [CoefW-1:0] coef_value = '0;
  logic out_ready = 1'b0;
  logic cfg_valid = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [CfgW-1:0] cfg_data = '0;
  logic in_ready, out_valid, cfg_ready;
  logic signed [SampleW-1:0] left_out, right_out;

  stereo_midside_resonant_widener_core dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid), .in_ready_o(in_ready), .kind_i(kind),
    .left_in_i(left_in), .right_in_i(right_in),
    .coef_index_i(coef_index), .coef_value_i(coef_value),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .left_out_o(left_out), .right_out_o(right_out),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Shadow of the block's registers and memories
  longint regs [7];
  longint coefs [NumCoef];
  longint delays [NumDelay];

  item_t pending [$];
  pair_t expected_pairs [$];
  int    errors = 0;
  bit    no_idle = 1'b0;
  int    hold_token = 0;

  function automatic longint mul_round(longint a, longint b, int sh);
    logic [63:0]  ua, ub;
    logic [127:0] p;
    bit neg;
    neg = (a < 0) != (b < 0);
    ua = a < 0 ? -a : a;
    ub = b < 0 ? -b : b;
    p = {64'd0, ua} * {64'd0, ub};
    p = (p + (128'd1 << (sh - 1))) >> sh;
    if (p > 128'(Clamp62)) p = 128'(Clamp62);
    return neg ? -longint'(p[63:0]) : longint'(p[63:0]);
  endfunction

  function automatic longint sat(longint v, int bits);
    longint lim;
    lim = (64'sd1 <<< (bits - 1)) - 1;
    if (v > lim) return lim;
    if (v < -lim - 1) return -lim - 1;
    return v;
  endfunction

  function automatic longint run_biquad(int f, longint x);
    longint g, p, t, d1, d2;
    g = mul_round(coefs[3*f], OneD + mul_round(x, regs[CFG_NONLIN], 16), 30);
    if (g < 0) g = -g;
    if (g > OneC) g = OneC;
    p = mul_round(x, g, 28);
    d1 = delays[2*f];
    d2 = delays[2*f+1];
    t = sat(p + d1, DelayW);
    delays[2*f]   = sat(d2 - mul_round(t, coefs[3*f+1], 28), DelayW);
    delays[2*f+1] = sat(-p - mul_round(t, coefs[3*f+2], 28), DelayW);
    return t;
  endfunction

  function automatic logic [SampleW-1:0] blend_out(longint wetv, longint dry);
    longint w;
    w = regs[CFG_WET_MIX];
    if (regs[CFG_OUTPUT_LEVEL] < Unity) wetv = mul_round(wetv, regs[CFG_OUTPUT_LEVEL], 16);
    if (w != Unity) wetv = mul_round(wetv, w, 16) + mul_round(dry, Unity - w, 16);
    return SampleW'(sat(mul_round(wetv, 1, 7), SampleW));
  endfunction

  function automatic void predict_item(item_t it);
    longint l, r, mid, side, iso_l, iso_r, ds, fm, fs, ms_l, ms_r, pl, pr, gm, gs;
    pair_t res;
    if (it.kind == KindCoef) begin
      if (it.idx < NumCoef) coefs[it.idx] = longint'(signed'(it.val));
      return;
    end
    l = longint'(signed'(it.l)) * 128;
    r = longint'(signed'(it.r)) * 128;
    mid = l + r;
    side = l - r;
    iso_l = mul_round(side, 1, 1);
    iso_r = mul_round(-side, 1, 1);
    ds = regs[CFG_DEPTH_SIDE];
    fm = run_biquad(0, mid);
    fm = fm - 2 * run_biquad(1, mid);
    fm = fm - 2 * run_biquad(2, mid);
    fs = 2 * run_biquad(3, side);
    fs = fs - 5 * run_biquad(4, side) + mul_round(side, ds, 16);
    fm = mul_round(fm, regs[CFG_DEPTH_MID], 16);
    fs = mul_round(fs, ds, 16);
    ms_l = mul_round(fm + fs, 1, 1);
    ms_r = mul_round(fm - fs, 1, 1);
    pl = run_biquad(5, iso_l);
    pr = run_biquad(6, iso_r);
    pl += 3 * run_biquad(7, iso_l);
    pr += 3 * run_biquad(8, iso_r);
    pl = ms_l + mul_round(pl, ds, 16);
    pr = ms_r + mul_round(pr, ds, 16);
    gm = mul_round(mid, regs[CFG_GAIN_MID], 16);
    gs = mul_round(side, regs[CFG_GAIN_SIDE], 16);
    res.l = blend_out(mul_round(gm + gs, 1, 1) + pl, l);
    res.r = blend_out(mul_round(gm - gs, 1, 1) + pr, r);
    expected_pairs.push_back(res);
  endfunction

  // Sender
  int tx_gap = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    item_t it;
    bit fire;
    if (!rst_ni) begin
      in_valid <= 1'b0;
      tx_gap <= 0;
    end else begin
      fire = in_valid && in_ready;
      if (fire) predict_item('{kind, left_in, right_in, coef_index, coef_value});
      if (fire || !in_valid) begin
        if (tx_gap > 0) begin
          tx_gap <= tx_gap - 1;
          in_valid <= 1'b0;
        end else if (pending.size() > 0) begin
          it = pending.pop_front();
          kind <= it.kind;
          left_in <= it.l;
          right_in <= it.r;
          coef_index <= it.idx;
          coef_value <= it.val;
          in_valid <= 1'b1;
          tx_gap <= no_idle ? 0 : $urandom_range(0, 10);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver and checker
  int rx_wait = 0, long_cnt = 0, hold_seen = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    pair_t e;
    int w;
    bit fire;
    if (!rst_ni) begin
      out_ready <= 1'b0;
      rx_wait <= 0;
      long_cnt <= 0;
    end else begin
      fire = out_valid && out_ready;
      if (fire) begin
        if (expected_pairs.size() == 0) begin
          $error("unexpected result item: left %0d right %0d", left_out, right_out);
          errors++;
        end else begin
          e = expected_pairs.pop_front();
          if (left_out !== e.l) begin
            $error("left_out: expected %0d, got %0d", signed'(e.l), left_out);
            errors++;
          end
          if (right_out !== e.r) begin
            $error("right_out: expected %0d, got %0d", signed'(e.r), right_out);
            errors++;
          end
        end
      end
      if (hold_token != hold_seen) begin
        hold_seen <= hold_token;
        long_cnt <= 4000;
        out_ready <= 1'b0;
      end else if (long_cnt > 0) begin
        long_cnt <= long_cnt - 1;
        out_ready <= 1'b0;
      end else if (fire) begin
        w = no_idle ? 0 : $urandom_range(0, 10);
        rx_wait <= w;
        out_ready <= (w == 0);
      end else if (rx_wait > 0) begin
        rx_wait <= rx_wait - 1;
        out_ready <= (rx_wait == 1);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  function automatic logic [CoefW-1:0] plausible_coef(int sel);
    case (sel)
      0:       return CoefW'($urandom_range(0, 107374182));
      1:       return CoefW'(int'($urandom_range(0, 1073741823)) - 536870912);
      default: return CoefW'($urandom_range(0, 255013683));
    endcase
  endfunction

  function automatic void push_coef(int idx, logic [CoefW-1:0] v);
    pending.push_back('{KindCoef, SampleW'($urandom), SampleW'($urandom), CoefIdxW'(idx), v});
  endfunction

  function automatic void push_pair(logic [SampleW-1:0] l, logic [SampleW-1:0] r);
    pending.push_back('{KindPair, l, r, CoefIdxW'($urandom), CoefW'($urandom)});
  endfunction

  function automatic logic [SampleW-1:0] draw_sample();
    case ($urandom_range(0, 3))
      0:       return SampleW'($urandom);
      1:       return $urandom_range(0, 1) ? 24'h7fffff : 24'h800000;
      default: return SampleW'(int'($urandom_range(0, 2097151)) - 1048576);
    endcase
  endfunction

  task automatic wait_idle();
    while (pending.size() != 0 || in_valid || expected_pairs.size() != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
  endtask

  task automatic write_regs(longint vals [7]);
    for (int i = 0; i < 7; i++) begin
      cfg_index <= CfgIdxW'(i);
      cfg_data <= CfgW'(vals[i]);
      cfg_valid <= 1'b1;
      do @(posedge clk_i); while (!cfg_ready);
      regs[i] = vals[i];
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic random_phase(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 6) == 0) begin
        if ($urandom_range(0, 7) == 0) push_coef($urandom_range(0, 31), CoefW'($urandom));
        else push_coef($urandom_range(0, 31), plausible_coef($urandom_range(0, 2)));
      end else begin
        push_pair(draw_sample(), draw_sample());
      end
    end
  endtask

  initial begin
    longint cfg [7];
    regs = '{65536, 65536, 32768, 32768, 65536, 0, 65536};
    foreach (coefs[i]) coefs[i] = 0;
    foreach (delays[i]) delays[i] = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset defaults: zero coefficients, then a full load, extremes and ignored writes
    push_pair(24'h7fffff, 24'h7fffff);
    for (int f = 0; f < NumFilt; f++)
      for (int k = 0; k < 3; k++) push_coef(3*f + k, plausible_coef(k));
    push_coef(27, 32'h7fffffff);
    push_coef(31, 32'h80000000);
    push_pair(24'h7fffff, 24'h7fffff);
    push_pair(24'h800000, 24'h800000);
    push_pair(24'h7fffff, 24'h800000);
    push_pair(24'h800000, 24'h7fffff);
    push_pair(24'h000000, 24'h000000);
    push_pair(24'hffffff, 24'h000001);
    random_phase(140);
    hold_token = 1;
    wait_idle();

    // Register maxima, nonlinearity at full
    cfg = '{65536, 262144, 131072, 131072, 65536, 65536, 65536};
    write_regs(cfg);
    push_coef(0, 32'h7fffffff);
    push_coef(1, 32'h80000000);
    random_phase(150);
    wait_idle();

    // Minima: no direct path, level pad to zero, fully dry
    cfg = '{0, 0, 0, 0, 0, 0, 0};
    write_regs(cfg);
    no_idle = 1'b1;
    random_phase(120);
    wait_idle();
    no_idle = 1'b0;

    // Full-width values, wet mix extrapolated above unity
    cfg = '{131071, 524287, 262143, 262143, 131071, 131071, 131071};
    write_regs(cfg);
    random_phase(100);
    wait_idle();

    for (int p = 0; p < 2; p++) begin
      cfg = '{$urandom_range(0, 65536), $urandom_range(0, 262144), $urandom_range(0, 131072),
              $urandom_range(0, 131072), $urandom_range(0, 65535), $urandom_range(0, 65536),
              $urandom_range(0, 65535)};
      write_regs(cfg);
      random_phase(100);
      hold_token = hold_token + 1;
      wait_idle();
    end

    if (errors == 0 && expected_pairs.size() == 0)
      $display("stereo_midside_resonant_widener_core_test: done, clean");
    else
      $display("stereo_midside_resonant_widener_core_test: done, errors");
    $finish;
  end

  initial begin
    #60ms;
    $display("stereo_midside_resonant_widener_core_test: done, errors");
    $finish;
  end

endmodule
